// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fug_pkg.sv -----
package fug_pkg;

    localparam int NUM_SLOTS_DEF   = 4;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int MAX_SLOTS       = 4;

    localparam int OP_W     = 3;
    localparam int IMG_W    = 8;
    localparam int SLOTS_W  = 3;
    localparam int WINDOW_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DRAIN  = 3'd1,
        PH_ARMED  = 3'd2,
        PH_ACTIVE = 3'd3,
        PH_LOCKED = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_RETRY = 2'd2,
        ACT_ABORT = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        NOTE_NONE     = 2'd0,
        NOTE_ACTIVE   = 2'd1,
        NOTE_INACTIVE = 2'd2
    } note_t;

    localparam logic [OP_W-1:0] OP_CHUNK   = 3'd0;
    localparam logic [OP_W-1:0] OP_STARTED = 3'd1;
    localparam logic [OP_W-1:0] OP_PENDING = 3'd2;
    localparam logic [OP_W-1:0] OP_STOPPED = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd5;

    // Per-item answer, excluding the derived pending_reset bit.
    typedef struct packed {
        logic   busy;
        act_t   act;
        note_t  note;
        phase_t phase;
    } result_t;

endpackage

// ----- src/fug_match.sv -----
module fug_match
    import fug_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic [SLOTS_W-1:0] slots_in_use,
    input  logic [IMG_W-1:0]   slot_image [NUM_SLOTS],
    input  logic [IMG_W-1:0]   chunk_img,
    output logic               hit
);

    logic [NUM_SLOTS-1:0] slot_hit;

    // Compare against the registered slots only; a count above NUM_SLOTS covers all.
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_hit[i] = (SLOTS_W'(i) < slots_in_use) && (slot_image[i] == chunk_img);
        end
    end

    assign hit = |slot_hit;

endmodule

// ----- src/fug_step.sv -----
module fug_step
    import fug_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic [OP_W-1:0]        op,
    input  logic                   first,
    input  logic                   drained,
    input  logic                   prot,
    input  phase_t                 phase,
    input  logic [COUNT_WIDTH-1:0] count,
    input  logic [COUNT_WIDTH-1:0] count_load,
    output phase_t                 phase_next,
    output logic [COUNT_WIDTH-1:0] count_next,
    output logic                   busy,
    output act_t                   act,
    output note_t                  note
);

    logic tick_expire;

    assign tick_expire = (count <= COUNT_WIDTH'(1));

    // Next phase and countdown.
    always_comb
    begin
        phase_next = phase;
        count_next = count;
        unique case (op)
            OP_CHUNK:
            begin
                if (first && !prot)
                begin
                    if (phase == PH_DRAIN || phase == PH_ARMED)
                    begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                    else if (phase == PH_ACTIVE)
                    begin
                        phase_next = PH_LOCKED;
                        count_next = '0;
                    end
                end
                else if (first && phase == PH_IDLE)
                begin
                    phase_next = drained ? PH_ARMED : PH_DRAIN;
                    count_next = drained ? count : count_load;
                end
                else if (first && phase == PH_DRAIN)
                begin
                    phase_next = drained ? PH_ARMED : PH_IDLE;
                    count_next = '0;
                end
            end
            OP_STARTED:
            begin
                if (phase == PH_ARMED)
                    phase_next = PH_ACTIVE;
            end
            OP_PENDING:
            begin
                if (phase == PH_ARMED || phase == PH_ACTIVE)
                begin
                    phase_next = PH_LOCKED;
                    count_next = '0;
                end
            end
            OP_STOPPED:
            begin
                if (phase == PH_ARMED)
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
                else if (phase == PH_ACTIVE)
                begin
                    phase_next = PH_LOCKED;
                    count_next = '0;
                end
            end
            OP_TICK:
            begin
                if (phase == PH_DRAIN)
                begin
                    phase_next = tick_expire ? PH_IDLE : PH_DRAIN;
                    count_next = tick_expire ? '0 : count - COUNT_WIDTH'(1);
                end
            end
            default:
            begin
                phase_next = phase;
            end
        endcase
    end

    // Answer fields.
    always_comb
    begin
        busy = 1'b0;
        act  = ACT_NONE;
        note = NOTE_NONE;
        unique case (op)
            OP_CHUNK:
            begin
                if (!first)
                    busy = prot && (phase == PH_IDLE || phase == PH_DRAIN);
                else if (!prot)
                begin
                    if (phase == PH_DRAIN || phase == PH_ARMED)
                        act = ACT_ABORT;
                    else if (phase == PH_ACTIVE)
                        note = NOTE_INACTIVE;
                end
                else if (phase == PH_IDLE)
                begin
                    act  = ACT_BEGIN;
                    busy = !drained;
                end
                else if (phase == PH_DRAIN)
                begin
                    act  = drained ? ACT_RETRY : ACT_ABORT;
                    busy = !drained;
                end
            end
            OP_STARTED:
            begin
                if (phase == PH_ARMED)
                    note = NOTE_ACTIVE;
            end
            OP_PENDING, OP_STOPPED:
            begin
                if (phase == PH_ACTIVE)
                    note = NOTE_INACTIVE;
                else if (op == OP_STOPPED && phase == PH_ARMED)
                    act = ACT_ABORT;
            end
            OP_TICK:
            begin
                if (phase == PH_DRAIN && tick_expire)
                    act = ACT_ABORT;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/firmware_upload_guard_fsm_core.sv -----
// Upload guard for protected firmware image slots.
//
// Input stream (s_*): one event per transfer. s_tuser carries the event kind
// (chunk, started, pending, stopped, tick); s_tdata carries the chunk's image
// index, its offset-zero flag and the readers-drained answer from the guard.
// Output stream (m_*): exactly one answer per event: busy, requested guard
// action, activity notice, the phase after the event, and the locked flag.
// Configuration: cfg_we/cfg_index/cfg_data write slot count, slot images and
// the retry window; write only while no answer is outstanding.
//
// The answer of an accepted event shows on m_tvalid in the next cycle. One event
// is taken per cycle while the answer register is empty or drained; the phase and
// countdown update in the same edge that loads the answer, so the next event sees them.
// A stalled answer holds in its register; s_tready stays high while m_tready
// is high, so back-to-back events flow as long as the receiver keeps taking.
// Reset clears the phase to idle, the countdown to zero and loads the
// configuration defaults (no slots in use, images 1..4, window 1000).
module firmware_upload_guard_fsm_core
    import fug_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // chunk_img[7:0], offset_is_zero[8],
                                             // readers_drained[9], zero fill
    input  logic [OP_W-1:0]       s_tuser,   // op[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // busy_res[0], guard_action[2:1],
                                             // notify[4:3], phase_now[7:5],
                                             // pending_reset[8], zero fill
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    // Width wide enough to compare the window against the counter limit.
    localparam int WIDE_W = (COUNT_WIDTH > WINDOW_W) ? COUNT_WIDTH : WINDOW_W;

    // Configuration registers.
    logic [SLOTS_W-1:0]  slots_in_use_reg;
    logic [IMG_W-1:0]    slot_image_reg [NUM_SLOTS];
    logic [WINDOW_W-1:0] retry_window_reg;

    // Guard state.
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    // Answer register.
    logic    m_tvalid_reg;
    result_t res_reg;
    result_t res_next;

    logic                   accept;
    logic                   prot;
    logic [WIDE_W-1:0]      window_wide;
    logic [WIDE_W-1:0]      count_max_wide;
    logic [COUNT_WIDTH-1:0] count_load;

    // Accept whenever the answer register is empty or being drained this cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Saturate the window to the counter width.
    assign window_wide    = WIDE_W'(retry_window_reg);
    assign count_max_wide = WIDE_W'({COUNT_WIDTH{1'b1}});
    assign count_load     = (window_wide > count_max_wide) ? {COUNT_WIDTH{1'b1}}
                                                           : COUNT_WIDTH'(window_wide);

    fug_match #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_match (
        .slots_in_use (slots_in_use_reg),
        .slot_image   (slot_image_reg),
        .chunk_img    (s_tdata[IMG_W-1:0]),
        .hit          (prot)
    );

    fug_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .op         (s_tuser),
        .first      (s_tdata[IMG_W]),
        .drained    (s_tdata[IMG_W+1]),
        .prot       (prot),
        .phase      (phase_reg),
        .count      (count_reg),
        .count_load (count_load),
        .phase_next (phase_next),
        .count_next (count_next),
        .busy       (res_next.busy),
        .act        (res_next.act),
        .note       (res_next.note)
    );

    assign res_next.phase = phase_next;

    // Configuration writes; writes to slots past NUM_SLOTS drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= '0;
            retry_window_reg <= WINDOW_RESET;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_image_reg[i] <= IMG_W'(i + 1);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SLOTS)
                slots_in_use_reg <= cfg_data[SLOTS_W-1:0];
            if (cfg_index == CFG_WINDOW)
                retry_window_reg <= cfg_data[WINDOW_W-1:0];
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (cfg_index == CFG_SLOT0 + CFG_IDX_W'(i))
                    slot_image_reg[i] <= cfg_data[IMG_W-1:0];
            end
        end
    end

    // Advance the guard state on every accepted event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Answer valid: load on accept, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (accept)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // Payload: hold while stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, (res_reg.phase == PH_LOCKED), res_reg.phase,
                       res_reg.note, res_reg.act, res_reg.busy};

endmodule

// ----- src/fug_checker.sv -----
`include "assert_macros.svh"

module fug_checker
    import fug_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic [2:0] ph;
    logic [1:0] act;
    logic [1:0] note;

    assign ph   = m_tdata[7:5];
    assign act  = m_tdata[2:1];
    assign note = m_tdata[4:3];

    // Locked flag tracks the reported phase.
    `ASSERT_IMPLY(a_lock_flag, clk, rst_n, m_tvalid, m_tdata[8] == (ph == PH_LOCKED), "pending_reset disagrees with phase")

    // A refused chunk leaves the guard idle or draining.
    `ASSERT_IMPLY(a_busy_phase, clk, rst_n, m_tvalid && m_tdata[0], ph == PH_IDLE || ph == PH_DRAIN, "busy outside idle or drain")

    // Notices match the phase reached.
    `ASSERT_IMPLY(a_note_phase, clk, rst_n, m_tvalid && note != NOTE_NONE, (note == NOTE_ACTIVE && ph == PH_ACTIVE) || (note == NOTE_INACTIVE && ph == PH_LOCKED), "notice inconsistent with phase")

    // Abort always releases to idle; begin lands in drain or armed.
    `ASSERT_IMPLY(a_act_phase, clk, rst_n, m_tvalid && act != ACT_NONE, (act == ACT_ABORT && ph == PH_IDLE) || (act == ACT_BEGIN && (ph == PH_DRAIN || ph == PH_ARMED)) || (act == ACT_RETRY && ph == PH_ARMED), "action inconsistent with phase")

    // A stalled answer holds.
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "answer changed while stalled")

endmodule

bind firmware_upload_guard_fsm_core fug_checker u_fug_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
